// File: rtl/core/pal_pkg.sv
// pal_pkg: shared types and constants of the page arena allocator
// holds beat payload structs, table entry type, alu and sequencer types
// no dependencies
package pal_pkg;

   localparam int ADDR_BITS        = 48;
   localparam int FREE_ENTRIES_DEF = 16;
   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int CSR_INDEX_BITS   = 1;

   typedef logic [ADDR_BITS-1:0] addr_type;

   // request operations
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_BREAK = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_REJECT = 2'd1;
   localparam logic [1:0] ST_NOMEM  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_START = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ARENA_END   = 1'b1;

   typedef struct packed {
      logic [1:0] operation;
      addr_type   address;
      addr_type   length;
      logic       anonymous;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      addr_type   result_address;
      logic       needs_zeroing;
   } rsp_type;

   typedef struct packed {
      addr_type base;
      addr_type size;
   } entry_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      addr_type   a;
      addr_type   b;
   } alu_req_type;

   // carry is carry out on add, borrow on subtract
   typedef struct packed {
      logic     carry;
      addr_type value;
   } alu_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_SPLIT,
      S_DROP,
      S_BUMP1,
      S_BUMP2,
      S_BUMP3,
      S_BUMP4,
      S_BRK1,
      S_BRK2,
      S_FCHK,
      S_FSCAN,
      S_FDEC,
      S_FBOTH1,
      S_FBOTH2,
      S_FNEXT,
      S_FPREV,
      S_UPSH,
      S_FPUT,
      S_DONE
   } state_type;

endpackage

// File: rtl/core/page_arena_allocator_core.sv
// page_arena_allocator_core: first-fit page allocator with a coalescing free table
// depends on pal_pkg and pal_alu
// Usage: one request beat gives exactly one response beat. An allocate is
// served from the free table, splitting a range or using one up; a miss
// falls through to the bump pointer. A free merges with one or both neighbor
// ranges or opens a table slot, and fails when the table is full and nothing
// merges. A request that fails its first checks goes straight to the response.
// Requests are served by one shared add/subtract unit and the free table
// memory with one read and one write port, walked one entry per cycle. The
// block takes a request only when its sequencer is idle; a finished response
// waits in an output register, so the next request may be taken while it is
// still unread. The free table has no reset and no clearing pass: only the
// first count entries are ever used.
module page_arena_allocator_core #(
   parameter int FREE_ENTRIES = pal_pkg::FREE_ENTRIES_DEF,
   parameter int PAGE_BYTES   = pal_pkg::PAGE_BYTES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pal_pkg::req_type                    req_data,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pal_pkg::rsp_type                    rsp_data,
   // configuration write port
   input  logic                                csr_we,
   input  logic [pal_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  pal_pkg::addr_type                   csr_wdata
);
   import pal_pkg::*;

   localparam int CW = $clog2(FREE_ENTRIES + 1);   // count and walk index width
   localparam int IW = $clog2(FREE_ENTRIES);       // table address width
   localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);
   localparam logic [CW-1:0] ONE        = CW'(1);
   localparam logic [CW-1:0] TWO        = CW'(2);
   localparam addr_type      PAGE_SLACK = addr_type'(PAGE_BYTES - 1);

   // sequencer and architectural state
   state_type        state_ff, state_in;
   addr_type         start_ff, start_in;
   addr_type         end_ff, end_in;
   addr_type         bump_ff, bump_in;
   logic             started_ff, started_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   // per-request working registers
   logic [CW-1:0]    idx_ff, idx_in;       // table walk position
   logic [CW-1:0]    sh_ff, sh_in;         // entry being moved
   logic [1:0]       op_ff, op_in;
   addr_type         addr_ff, addr_in;
   addr_type         len_ff, len_in;       // raw length, then page-rounded size
   logic             anon_ff, anon_in;
   addr_type         tmp_ff, tmp_in;       // remainder / partial sum
   logic [ADDR_BITS:0] span_ff, span_in;   // end of the freed range, may reach 2^ADDR_BITS
   entry_type        prev_ff, prev_in;     // last entry below the freed range
   entry_type        cur_ff, cur_in;       // first entry at or above the freed range
   logic [1:0]       res_status_ff, res_status_in;
   addr_type         res_addr_ff, res_addr_in;
   logic             res_zero_ff, res_zero_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_load;

   // free table memory
   entry_type        table_mem [FREE_ENTRIES];
   entry_type        rd_data_ff;
   logic [CW-1:0]    rd_idx;
   logic             mem_we;
   logic [CW-1:0]    mem_widx;
   entry_type        mem_wdata;

   // shared arithmetic
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;

   // helper terms
   logic [CW-1:0]    idx_next;
   logic [CW-1:0]    idx_prev;
   logic [CW-1:0]    sh_plus2;
   logic             last_scan;
   addr_type         bump_eff;
   addr_type         rounded;
   logic             join_next;
   logic             join_prev;
   logic             range_wraps;

   pal_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign idx_next    = idx_ff + ONE;
   assign idx_prev    = idx_ff - ONE;
   assign sh_plus2    = sh_ff + TWO;
   assign last_scan   = (idx_next == cnt_ff);
   // first bump or break loads the pointer from the arena start
   assign bump_eff    = started_ff ? bump_ff : start_ff;
   assign rounded     = alu_rsp.value & ~PAGE_SLACK;
   // freed range may end exactly at the top of the address space, not past it
   assign range_wraps = alu_rsp.carry && (alu_rsp.value != '0);
   // neighbor tests, valid in S_FDEC only
   assign join_next   = (idx_ff != cnt_ff) && (span_ff == {1'b0, cur_ff.base});
   assign join_prev   = (idx_ff != '0) && !alu_rsp.carry && (alu_rsp.value == addr_ff);

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // configuration decode
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ARENA_START: start_in = csr_wdata;
            CSR_ARENA_END:   end_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // operand select for the shared unit, by state only
   always_comb begin
      alu_req = '{op: ALU_ADD, a: '0, b: '0};
      unique case (state_ff)
         S_DECODE: alu_req = '{op: ALU_ADD, a: len_ff,          b: PAGE_SLACK};
         S_SCAN:   alu_req = '{op: ALU_SUB, a: rd_data_ff.size, b: len_ff};
         S_SPLIT:  alu_req = '{op: ALU_ADD, a: res_addr_ff,     b: len_ff};
         S_BUMP1:  alu_req = '{op: ALU_ADD, a: bump_eff,        b: PAGE_SLACK};
         S_BUMP2:  alu_req = '{op: ALU_SUB, a: end_ff,          b: res_addr_ff};
         S_BUMP3:  alu_req = '{op: ALU_SUB, a: tmp_ff,          b: len_ff};
         S_BUMP4:  alu_req = '{op: ALU_ADD, a: res_addr_ff,     b: len_ff};
         S_BRK1:   alu_req = '{op: ALU_SUB, a: addr_ff,         b: start_ff};
         S_BRK2:   alu_req = '{op: ALU_SUB, a: end_ff,          b: addr_ff};
         S_FCHK:   alu_req = '{op: ALU_ADD, a: addr_ff,         b: len_ff};
         S_FSCAN:  alu_req = '{op: ALU_SUB, a: rd_data_ff.base, b: addr_ff};
         S_FDEC:   alu_req = '{op: ALU_ADD, a: prev_ff.base,    b: prev_ff.size};
         S_FBOTH1: alu_req = '{op: ALU_ADD, a: prev_ff.size,    b: len_ff};
         S_FBOTH2: alu_req = '{op: ALU_ADD, a: tmp_ff,          b: cur_ff.size};
         S_FNEXT:  alu_req = '{op: ALU_ADD, a: cur_ff.size,     b: len_ff};
         S_FPREV:  alu_req = '{op: ALU_ADD, a: prev_ff.size,    b: len_ff};
         default:  ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (!anon_ff || len_ff == '0 || alu_rsp.carry) state_in = S_DONE;
                  else if (cnt_ff == '0)                         state_in = S_BUMP1;
                  else                                           state_in = S_SCAN;
               end
               OP_FREE: begin
                  if (addr_ff == '0 || len_ff == '0 || alu_rsp.carry) state_in = S_DONE;
                  else                                                 state_in = S_FCHK;
               end
               OP_BREAK: state_in = S_BRK1;
               default:  state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            if (!alu_rsp.carry) begin
               if (alu_rsp.value != '0)     state_in = S_SPLIT;
               else if (idx_next < cnt_ff)  state_in = S_DROP;
               else                         state_in = S_DONE;
            end else if (last_scan) begin
               state_in = S_BUMP1;
            end
         end
         S_SPLIT: state_in = S_DONE;
         S_DROP: begin
            if (!(sh_plus2 < cnt_ff)) state_in = S_DONE;
         end
         S_BUMP1: state_in = alu_rsp.carry ? S_DONE : S_BUMP2;
         S_BUMP2: state_in = alu_rsp.carry ? S_DONE : S_BUMP3;
         S_BUMP3: state_in = alu_rsp.carry ? S_DONE : S_BUMP4;
         S_BUMP4: state_in = S_DONE;
         S_BRK1:  state_in = alu_rsp.carry ? S_DONE : S_BRK2;
         S_BRK2:  state_in = S_DONE;
         S_FCHK: begin
            if (range_wraps)        state_in = S_DONE;
            else if (cnt_ff == '0)  state_in = S_FDEC;
            else                    state_in = S_FSCAN;
         end
         S_FSCAN: begin
            if (!alu_rsp.carry || last_scan) state_in = S_FDEC;
         end
         S_FDEC: begin
            if (join_next && join_prev)    state_in = S_FBOTH1;
            else if (join_next)            state_in = S_FNEXT;
            else if (join_prev)            state_in = S_FPREV;
            else if (cnt_ff == FULL_COUNT) state_in = S_DONE;
            else if (idx_ff == cnt_ff)     state_in = S_FPUT;
            else                           state_in = S_UPSH;
         end
         S_FBOTH1: state_in = S_FBOTH2;
         S_FBOTH2: state_in = (idx_next < cnt_ff) ? S_DROP : S_DONE;
         S_FNEXT:  state_in = S_DONE;
         S_FPREV:  state_in = S_DONE;
         S_UPSH: begin
            if (!(sh_ff > idx_next)) state_in = S_FPUT;
         end
         S_FPUT: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, table ports and bookkeeping
   always_comb begin
      idx_in        = idx_ff;
      sh_in         = sh_ff;
      cnt_in        = cnt_ff;
      bump_in       = bump_ff;
      started_in    = started_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      len_in        = len_ff;
      anon_in       = anon_ff;
      tmp_in        = tmp_ff;
      span_in       = span_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      res_zero_in   = res_zero_ff;
      rd_idx        = '0;
      mem_we        = 1'b0;
      mem_widx      = '0;
      mem_wdata     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_data.operation;
               addr_in       = req_data.address;
               len_in        = req_data.length;
               anon_in       = req_data.anonymous;
               res_status_in = ST_OK;
               res_addr_in   = '0;
               res_zero_in   = 1'b0;
               idx_in        = '0;
            end
         end
         S_DECODE: begin
            unique case (op_ff)
               OP_ALLOC: begin
                  if (!anon_ff || len_ff == '0) res_status_in = ST_REJECT;
                  else if (alu_rsp.carry)       res_status_in = ST_NOMEM;
                  else                          len_in = rounded;
               end
               OP_FREE: begin
                  if (addr_ff == '0 || len_ff == '0) res_status_in = ST_OK;
                  else if (alu_rsp.carry)            res_status_in = ST_REJECT;
                  else                               len_in = rounded;
               end
               OP_BREAK: ;
               default:  res_status_in = ST_REJECT;
            endcase
         end
         S_SCAN: begin
            // prefetch the next entry; also the first move of a drop
            rd_idx = idx_next;
            if (!alu_rsp.carry) begin
               res_addr_in = rd_data_ff.base;
               res_zero_in = 1'b1;
               tmp_in      = alu_rsp.value;
               sh_in       = idx_ff;
               if (alu_rsp.value == '0 && last_scan) cnt_in = cnt_ff - ONE;
            end else begin
               idx_in = idx_next;
            end
         end
         S_SPLIT: begin
            mem_we    = 1'b1;
            mem_widx  = idx_ff;
            mem_wdata = '{base: alu_rsp.value, size: tmp_ff};
         end
         S_DROP: begin
            // close the gap: entry sh takes entry sh+1
            mem_we    = 1'b1;
            mem_widx  = sh_ff;
            mem_wdata = rd_data_ff;
            rd_idx    = sh_plus2;
            sh_in     = sh_ff + ONE;
            if (!(sh_plus2 < cnt_ff)) cnt_in = cnt_ff - ONE;
         end
         S_BUMP1: begin
            started_in = 1'b1;
            bump_in    = bump_eff;
            if (alu_rsp.carry) res_status_in = ST_NOMEM;
            else               res_addr_in   = rounded;
         end
         S_BUMP2: begin
            // aligned pointer already past the arena end
            if (alu_rsp.carry) begin
               res_status_in = ST_NOMEM;
               res_addr_in   = '0;
            end else begin
               tmp_in = alu_rsp.value;
            end
         end
         S_BUMP3: begin
            if (alu_rsp.carry) begin
               res_status_in = ST_NOMEM;
               res_addr_in   = '0;
            end
         end
         S_BUMP4: begin
            bump_in       = alu_rsp.value;
            res_status_in = ST_OK;
         end
         S_BRK1: begin
            started_in    = 1'b1;
            bump_in       = bump_eff;
            res_status_in = ST_OK;
            res_addr_in   = bump_eff;
         end
         S_BRK2: begin
            if (!alu_rsp.carry) begin
               bump_in     = addr_ff;
               res_addr_in = addr_ff;
            end
         end
         S_FCHK: begin
            span_in = {alu_rsp.carry, alu_rsp.value};
            idx_in  = '0;
            rd_idx  = '0;
            if (range_wraps) res_status_in = ST_REJECT;
         end
         S_FSCAN: begin
            rd_idx = idx_next;
            if (alu_rsp.carry) begin
               prev_in = rd_data_ff;
               idx_in  = idx_next;
            end else begin
               cur_in = rd_data_ff;
            end
         end
         S_FDEC: begin
            // fetch the top entry in case the table must open a slot
            rd_idx = cnt_ff - ONE;
            sh_in  = cnt_ff;
            if (!join_next && !join_prev && cnt_ff == FULL_COUNT) res_status_in = ST_FULL;
         end
         S_FBOTH1: begin
            tmp_in = alu_rsp.value;
         end
         S_FBOTH2: begin
            mem_we    = 1'b1;
            mem_widx  = idx_prev;
            mem_wdata = '{base: prev_ff.base, size: alu_rsp.value};
            rd_idx    = idx_next;
            sh_in     = idx_ff;
            if (last_scan) cnt_in = cnt_ff - ONE;
         end
         S_FNEXT: begin
            mem_we    = 1'b1;
            mem_widx  = idx_ff;
            mem_wdata = '{base: addr_ff, size: alu_rsp.value};
         end
         S_FPREV: begin
            mem_we    = 1'b1;
            mem_widx  = idx_prev;
            mem_wdata = '{base: prev_ff.base, size: alu_rsp.value};
         end
         S_UPSH: begin
            // open a slot: entry sh takes entry sh-1
            mem_we    = 1'b1;
            mem_widx  = sh_ff;
            mem_wdata = rd_data_ff;
            rd_idx    = sh_ff - TWO;
            sh_in     = sh_ff - ONE;
         end
         S_FPUT: begin
            mem_we    = 1'b1;
            mem_widx  = idx_ff;
            mem_wdata = '{base: addr_ff, size: len_ff};
            cnt_in    = cnt_ff + ONE;
         end
         S_DONE: ;
         default: ;
      endcase
   end

   // output register: loads when empty or being drained
   assign rsp_load     = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_data_in  = rsp_load ? rsp_type'{status:         res_status_ff,
                                              result_address: res_addr_ff,
                                              needs_zeroing:  res_zero_ff}
                                  : rsp_data_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= '0;
         end_ff       <= '0;
         bump_ff      <= '0;
         started_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         bump_ff      <= bump_in;
         started_ff   <= started_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      sh_ff         <= sh_in;
      op_ff         <= op_in;
      addr_ff       <= addr_in;
      len_ff        <= len_in;
      anon_ff       <= anon_in;
      tmp_ff        <= tmp_in;
      span_ff       <= span_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      res_zero_ff   <= res_zero_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // free table: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_widx[IW-1:0]] <= mem_wdata;
      rd_data_ff <= table_mem[rd_idx[IW-1:0]];
   end

endmodule

// File: rtl/core/pal_alu.sv
// pal_alu: shared add / subtract unit of the allocator sequencer
// depends on pal_pkg
module pal_alu (
   input  pal_pkg::alu_req_type alu_req,
   output pal_pkg::alu_rsp_type alu_rsp
);
   import pal_pkg::*;

   logic [ADDR_BITS:0] result;

   always_comb begin
      unique case (alu_req.op)
         ALU_ADD: result = {1'b0, alu_req.a} + {1'b0, alu_req.b};
         ALU_SUB: result = {1'b0, alu_req.a} - {1'b0, alu_req.b};
         default: result = '0;
      endcase
      alu_rsp.carry = result[ADDR_BITS];
      alu_rsp.value = result[ADDR_BITS-1:0];
   end

endmodule

// File: rtl/core/pal_core_checker.sv
// pal_core_checker: port-level checks on page_arena_allocator_core
// depends on pal_pkg; bound to the core at the end of this file
module pal_core_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pal_pkg::rsp_type rsp_data
);
   import pal_pkg::*;

   logic [1:0] pend_ff;
   logic [1:0] pend_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat)      pend_in = pend_ff + 2'd1;
      else if (!req_beat && rsp_beat) pend_in = pend_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // the sequencer is busy for at least the cycle after a request beat
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_ready)
      else $error("request taken back to back");

   // no response beat without a request that owns it
   a_rsp_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response without request");

   // failures carry neither an address nor the zeroing flag
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.result_address == '0 && !rsp_data.needs_zeroing)
      else $error("failed response carries data");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind page_arena_allocator_core pal_core_checker u_pal_core_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// File: bench/page_arena_allocator_core_tb.sv
// page_arena_allocator_core_tb: self-checking bench for the page arena allocator core
// runs alloc, free and set-break beats against an in-bench allocator predictor
// depends on pal_pkg and page_arena_allocator_core
module page_arena_allocator_core_tb;
   import pal_pkg::*;

   localparam int       TABLE_DEPTH   = FREE_ENTRIES_DEF;
   localparam addr_type PAGE          = addr_type'(PAGE_BYTES_DEF);
   localparam addr_type PAGE_MASK     = PAGE - addr_type'(1);
   localparam addr_type TOP           = '1;
   localparam logic [1:0] OP_UNUSED   = 2'd3;   // undefined operation, must be rejected
   localparam int       STALL_LIMIT   = 5000;   // cycles without any beat before giving up
   localparam int       SETTLE_CYCLES = 80;     // well past the longest request
   localparam int       PHASE_ITEMS   = 340;
   localparam int       HOLD_CYCLES   = 400;

   typedef enum logic [1:0] {PACE_FULL, PACE_BUSY, PACE_SPARSE, PACE_RUNS} pace_type;

   logic      clock;
   logic      reset     = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   req_type   req_data  = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   rsp_type   rsp_data;
   logic      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_ARENA_START;
   addr_type  csr_wdata = '0;

   page_arena_allocator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // allocator predictor state: arena bounds, bump pointer, free table
   // ---------------------------------------------------------------------
   addr_type  arena_lo  = '0;
   addr_type  arena_hi  = '0;
   addr_type  bump_ptr  = '0;
   bit        bump_live = 1'b0;
   addr_type  tab_base [TABLE_DEPTH];
   addr_type  tab_size [TABLE_DEPTH];
   int        tab_count = 0;

   entry_type held_ranges[$];        // ranges handed out, candidates for well-formed frees
   req_type   requests_to_send[$];   // beats waiting for the driver
   rsp_type   outcomes_due[$];       // predicted responses, oldest first
   int        errors = 0;

   // address window the random frees aim at in the current phase
   addr_type  win_base  = '0;
   int        win_pages = 64;

   function automatic addr_type rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_BITS-1:0];
   endfunction

   // round up to whole pages; fails when the result would leave the address space
   function automatic bit page_round(input addr_type x, output addr_type r);
      r = '0;
      if (x > TOP - PAGE_MASK)
         return 1'b0;
      r = (x + PAGE_MASK) & ~PAGE_MASK;
      return 1'b1;
   endfunction

   // bump pointer is loaded from the arena floor on first use only
   function automatic void begin_bump();
      if (!bump_live) begin
         bump_ptr  = arena_lo;
         bump_live = 1'b1;
      end
   endfunction

   function automatic void drop_entry(input int idx);
      int k;
      for (k = idx; k < tab_count - 1; k++) begin
         tab_base[k] = tab_base[k+1];
         tab_size[k] = tab_size[k+1];
      end
      tab_count--;
   endfunction

   // expected response for one accepted request beat; updates the predictor state
   function automatic rsp_type arena_outcome(input req_type r);
      rsp_type   o;
      addr_type  n, p;
      logic [ADDR_BITS:0] tail;
      int        i, k, idx;
      bit        hit, join_next, join_prev;
      entry_type got;
      o.status         = ST_REJECT;
      o.result_address = '0;
      o.needs_zeroing  = 1'b0;
      hit = 1'b0;
      idx = 0;
      case (r.operation)
         OP_ALLOC: begin
            if (r.anonymous && r.length != '0) begin
               if (!page_round(r.length, n)) begin
                  o.status = ST_NOMEM;
               end else begin
                  // first fit over the address-ordered table
                  for (i = 0; i < tab_count; i++) begin
                     if (!hit && tab_size[i] >= n) begin
                        hit = 1'b1;
                        idx = i;
                     end
                  end
                  if (hit) begin
                     o.status         = ST_OK;
                     o.result_address = tab_base[idx];
                     o.needs_zeroing  = 1'b1;
                     if (tab_size[idx] == n) begin
                        drop_entry(idx);
                     end else begin
                        tab_base[idx] = tab_base[idx] + n;
                        tab_size[idx] = tab_size[idx] - n;
                     end
                  end else begin
                     begin_bump();
                     if (!page_round(bump_ptr, p)) begin
                        o.status = ST_NOMEM;
                     end else if (p > arena_hi || n > arena_hi - p) begin
                        o.status = ST_NOMEM;
                     end else begin
                        bump_ptr         = p + n;
                        o.status         = ST_OK;
                        o.result_address = p;
                     end
                  end
                  if (o.status == ST_OK) begin
                     got.base = o.result_address;
                     got.size = n;
                     held_ranges.push_back(got);
                     if (held_ranges.size() > 48)
                        void'(held_ranges.pop_front());
                  end
               end
            end
         end
         OP_FREE: begin
            if (r.address == '0 || r.length == '0) begin
               o.status = ST_OK;
            end else if (!page_round(r.length, n)) begin
               o.status = ST_REJECT;
            end else if (n - addr_type'(1) > TOP - r.address) begin
               o.status = ST_REJECT;
            end else begin
               o.status = ST_OK;
               // end of the freed range may be exactly one past the top of memory
               tail = {1'b0, r.address} + {1'b0, n};
               i = 0;
               while (i < tab_count && tab_base[i] < r.address)
                  i++;
               join_next = (i < tab_count) && (tail == {1'b0, tab_base[i]});
               join_prev = (i > 0) &&
                           ({1'b0, tab_base[i-1]} + {1'b0, tab_size[i-1]} == {1'b0, r.address});
               if (join_next && join_prev) begin
                  tab_size[i-1] = tab_size[i-1] + n + tab_size[i];
                  drop_entry(i);
               end else if (join_next) begin
                  tab_base[i] = r.address;
                  tab_size[i] = tab_size[i] + n;
               end else if (join_prev) begin
                  tab_size[i-1] = tab_size[i-1] + n;
               end else if (tab_count >= TABLE_DEPTH) begin
                  o.status = ST_FULL;
               end else begin
                  for (k = tab_count; k > i; k--) begin
                     tab_base[k] = tab_base[k-1];
                     tab_size[k] = tab_size[k-1];
                  end
                  tab_base[i] = r.address;
                  tab_size[i] = n;
                  tab_count++;
               end
            end
         end
         OP_BREAK: begin
            begin_bump();
            if (r.address >= arena_lo && r.address <= arena_hi)
               bump_ptr = r.address;
            o.status         = ST_OK;
            o.result_address = bump_ptr;
         end
         default: ;
      endcase
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // request driver: bursts of beats with random gaps, prediction on accept
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            outcomes_due.push_back(arena_outcome(req_data));
         if (req_valid && !req_ready) begin
            // beat still pending, keep valid and payload as they are
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (requests_to_send.size() != 0) begin
            req_data  <= requests_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left == 0)
               burst_left = int'($urandom_range(40, 1));
            burst_left--;
            // half the bursts run straight into the next one
            if (burst_left == 0)
               gap_left = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(15, 1));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // response monitor and receiver pacing
   // ---------------------------------------------------------------------
   int       rsp_seen  = 0;
   int       hold_left = 0;
   int       mode_left = 0;
   int       pace_tick = 0;
   pace_type pace      = PACE_FULL;
   logic     ready_next;
   rsp_type  want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outcomes_due.size() == 0) begin
               errors++;
               $display("%0t: response beat %0d with nothing expected: status %0d addr %h zero %0b",
                        $time, rsp_seen, rsp_data.status, rsp_data.result_address,
                        rsp_data.needs_zeroing);
            end else begin
               want = outcomes_due.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.result_address !== want.result_address ||
                   rsp_data.needs_zeroing !== want.needs_zeroing) begin
                  errors++;
                  $display("%0t: beat %0d expected status %0d addr %h zero %0b, got status %0d addr %h zero %0b",
                           $time, rsp_seen, want.status, want.result_address, want.needs_zeroing,
                           rsp_data.status, rsp_data.result_address, rsp_data.needs_zeroing);
               end
            end
            rsp_seen++;
            // long hold-offs so the core backs up and stalls its request side
            if (rsp_seen == 40 || rsp_seen == 1200)
               hold_left = HOLD_CYCLES;
         end
         pace_tick++;
         if (mode_left == 0) begin
            pace      = pace_type'($urandom_range(3));
            mode_left = int'($urandom_range(200, 20));
         end else begin
            mode_left--;
         end
         case (pace)
            PACE_FULL:   ready_next = 1'b1;
            PACE_BUSY:   ready_next = ($urandom_range(9) < 7);
            PACE_SPARSE: ready_next = ($urandom_range(9) < 2);
            default:     ready_next = ((pace_tick % 16) < 11);
         endcase
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end
         rsp_ready <= ready_next;
      end
   end

   // watchdog: no beat on either side for too long ends the run
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("page_arena_allocator_core test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_req(input logic [1:0] op, input addr_type a, input addr_type len,
                            input logic anon);
      req_type r;
      r.operation = op;
      r.address   = a;
      r.length    = len;
      r.anonymous = anon;
      while (requests_to_send.size() >= 6)
         @(negedge clock);
      requests_to_send.push_back(r);
   endtask

   // all beats sent and answered, then let the sequencer finish for sure
   task automatic wait_quiet();
      while (requests_to_send.size() != 0 || req_valid || outcomes_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // both arena registers, written back to back while the core is idle
   task automatic set_arena(input addr_type lo, input addr_type hi);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_ARENA_START;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_ARENA_END;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we    <= 1'b0;
      arena_lo = lo;
      arena_hi = hi;
   endtask

   // ---------------------------------------------------------------------
   // stimulus: directed corners, then random phases over several arenas
   // ---------------------------------------------------------------------
   initial begin : stimulus
      req_type     r;
      int          ph, n, k, pick, sel;
      addr_type    lo, hi;
      logic [63:0] span;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // small arena with an unaligned floor
      set_arena(48'h0000_0001_0123, 48'h0000_0003_0000);
      queue_req(OP_ALLOC, rand_addr(), '0, 1'b1);            // zero length
      queue_req(OP_ALLOC, '0, PAGE, 1'b0);                    // file mapping
      queue_req(OP_ALLOC, TOP, 48'h1, 1'b1);                  // first bump, floor rounded up
      queue_req(OP_ALLOC, '0, 48'h2001, 1'b1);
      queue_req(OP_ALLOC, '0, TOP, 1'b1);                     // rounding leaves address space
      queue_req(OP_ALLOC, '0, TOP - PAGE_MASK, 1'b1);         // largest roundable, no room
      queue_req(OP_FREE, '0, PAGE, 1'b0);                     // ignored, address zero
      queue_req(OP_FREE, 48'h11000, '0, 1'b0);                // ignored, length zero
      queue_req(OP_FREE, 48'h11000, 48'h1, 1'b0);
      queue_req(OP_FREE, 48'h13000, PAGE, 1'b0);
      queue_req(OP_FREE, 48'h12000, PAGE, 1'b1);              // merges both neighbors
      queue_req(OP_FREE, 48'h14000, 48'hfff, 1'b0);           // merges with previous
      queue_req(OP_FREE, 48'h10000, PAGE, 1'b0);              // merges with next
      queue_req(OP_ALLOC, '0, 48'h2000, 1'b1);                // split a table range
      queue_req(OP_ALLOC, '0, 48'h3000, 1'b1);                // uses a range up exactly
      queue_req(OP_FREE, TOP - PAGE_MASK, PAGE, 1'b0);        // last page of address space
      queue_req(OP_FREE, TOP - 48'hffe, PAGE, 1'b0);          // runs past the top
      queue_req(OP_FREE, 48'h20000, TOP, 1'b0);               // length rounds past the top
      queue_req(OP_BREAK, 48'h20000, TOP, 1'b1);
      queue_req(OP_BREAK, 48'h5, '0, 1'b0);                   // below the floor
      queue_req(OP_BREAK, TOP, '0, 1'b0);                     // above the end
      queue_req(OP_BREAK, 48'h30000, '0, 1'b0);               // exactly the end
      queue_req(OP_ALLOC, '0, PAGE, 1'b1);                    // comes from the top page entry
      queue_req(OP_ALLOC, '0, PAGE, 1'b1);                    // bump at the end, out of memory
      queue_req(OP_UNUSED, TOP, TOP, 1'b1);
      queue_req(OP_BREAK, 48'h10123, '0, 1'b0);               // exactly the floor, unaligned
      queue_req(OP_ALLOC, '0, 48'h1800, 1'b1);                // unaligned pointer rounds up

      for (ph = 0; ph < 6; ph++) begin
         wait_quiet();
         win_pages = 64;
         case (ph)
            0: begin
               lo       = addr_type'(32'h0010_0000) + addr_type'($urandom_range(4095));
               hi       = lo + PAGE * addr_type'(64);
               win_base = (lo + PAGE_MASK) & ~PAGE_MASK;
            end
            1: begin
               // widest arena
               lo       = '0;
               hi       = TOP;
               win_base = rand_addr() & 48'h0000_ffff_f000;
            end
            2: begin
               // floor above the end: every break is out of range
               lo       = 48'h0000_0008_0000;
               hi       = 48'h0000_0004_0000;
               win_base = 48'h0000_0004_0000;
            end
            3: begin
               // top of the address space: pointer rounding can overflow
               lo        = TOP - 48'h7fff;
               hi        = TOP;
               win_base  = lo;
               win_pages = 8;
            end
            4: begin
               lo       = '0;
               hi       = '0;
               win_base = 48'h0000_0020_0000;
            end
            default: begin
               lo       = rand_addr() & 48'h0000_ffff_f000;
               hi       = lo + PAGE * addr_type'($urandom_range(96, 16));
               win_base = (lo + PAGE_MASK) & ~PAGE_MASK;
            end
         endcase
         set_arena(lo, hi);

         // try to move the pointer into the window, then scatter single pages to fill the table
         queue_req(OP_BREAK, win_base, rand_addr(), 1'b1);
         for (k = 0; k < win_pages / 2 && k < 18; k++)
            queue_req(OP_FREE, win_base + PAGE * addr_type'(2 * k),
                      PAGE - addr_type'($urandom_range(4095)), $urandom_range(1) != 0);

         for (n = 0; n < PHASE_ITEMS; n++) begin
            r.operation = OP_ALLOC;
            r.address   = rand_addr();
            r.length    = '0;
            r.anonymous = 1'b1;
            pick = int'($urandom_range(99));
            sel  = int'($urandom_range(99));
            if (pick < 42) begin
               if (sel < 70)
                  r.length = addr_type'($urandom_range(4 * PAGE_BYTES_DEF, 1));
               else if (sel < 78)
                  r.length = '0;
               else if (sel < 85)
                  r.length = rand_addr();
               else if (sel < 90)
                  r.length = TOP - addr_type'($urandom_range(2 * PAGE_BYTES_DEF));
               else
                  r.length = PAGE * addr_type'($urandom_range(16, 1));
               r.anonymous = ($urandom_range(11) != 0);
            end else if (pick < 80) begin
               r.operation = OP_FREE;
               r.anonymous = $urandom_range(1) != 0;
               if (sel < 50 && held_ranges.size() != 0) begin
                  // give back something that was handed out
                  k = int'($urandom_range(held_ranges.size() - 1));
                  r.address = held_ranges[k].base;
                  r.length  = held_ranges[k].size - addr_type'($urandom_range(4095));
                  held_ranges.delete(k);
               end else if (sel < 80) begin
                  r.address = win_base + PAGE * addr_type'($urandom_range(win_pages - 1));
                  r.length  = PAGE * addr_type'($urandom_range(3, 1))
                              - addr_type'($urandom_range(4095));
               end else if (sel < 86) begin
                  r.length = rand_addr();
               end else if (sel < 90) begin
                  r.address = '0;
                  r.length  = addr_type'($urandom_range(8 * PAGE_BYTES_DEF));
               end else if (sel < 94) begin
                  r.length = '0;
               end else begin
                  r.address = TOP - addr_type'($urandom_range(3 * PAGE_BYTES_DEF));
                  r.length  = addr_type'($urandom_range(2 * PAGE_BYTES_DEF, 1));
               end
            end else if (pick < 96) begin
               r.operation = OP_BREAK;
               r.length    = rand_addr();
               r.anonymous = $urandom_range(1) != 0;
               if (sel < 60 && arena_lo <= arena_hi) begin
                  span      = {16'd0, arena_hi} - {16'd0, arena_lo} + 64'd1;
                  r.address = arena_lo + addr_type'({$urandom, $urandom} % span);
               end else if (sel < 75) begin
                  r.address = arena_lo;
               end else if (sel < 90) begin
                  r.address = arena_hi;
               end
            end else begin
               r.operation = OP_UNUSED;
               r.length    = rand_addr();
               r.anonymous = $urandom_range(1) != 0;
            end
            queue_req(r.operation, r.address, r.length, r.anonymous);
         end
      end

      wait_quiet();
      if (errors == 0 && outcomes_due.size() == 0)
         $display("page_arena_allocator_core test passed");
      else
         $display("page_arena_allocator_core test failed");
      $finish;
   end

endmodule

// File: files.f
rtl/core/pal_pkg.sv
rtl/core/pal_alu.sv
rtl/core/page_arena_allocator_core.sv
rtl/core/pal_core_checker.sv
bench/page_arena_allocator_core_tb.sv
